/* rtl/tile_mosaic_address_map_unit_assert.svh */
// Assertion macros shared by the tile mosaic address map RTL.
// Depends on nothing; included by the files that check their own logic.
`ifndef TILE_MOSAIC_ADDRESS_MAP_UNIT_ASSERT_SVH
`define TILE_MOSAIC_ADDRESS_MAP_UNIT_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define TMAM_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("tmam check failed");

// When the first expression holds, the second holds in the next cycle.
`define TMAM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tmam check failed");

`endif

/* rtl/tmam_pkg.sv */
// Shared widths, codes and payload types of the tile mosaic address map.
// Depends on nothing; used by every module of the block.
package tmam_pkg;

    localparam int CFG_W       = 13;
    localparam int POS_W       = 12;
    localparam int IDX_W       = 24;
    localparam int ST_W        = 2;
    localparam int CIDX_W      = 2;
    localparam int MAX_DIM_DEF = 4096;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_N   = 2'd1;
    localparam logic [ST_W-1:0] ST_OUTSIDE = 2'd2;

    localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] REG_TILE_N = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic [CFG_W-1:0] tile_n;
        logic [CFG_W-1:0] quot_w;
        logic [CFG_W-1:0] rem_w;
        logic [CFG_W-1:0] border_w;
        logic [CFG_W-1:0] quot_h;
        logic [CFG_W-1:0] rem_h;
        logic [CFG_W-1:0] border_h;
        logic             busy;
    } cfg_view_t;

    typedef struct packed {
        logic [CFG_W-1:0] rem;
        logic [POS_W-1:0] dvd;
        logic [POS_W-1:0] quo;
        logic [CFG_W-1:0] div;
        logic [POS_W-1:0] base;
    } axis_t;

    typedef struct packed {
        axis_t            row_ax;
        axis_t            col_ax;
        logic [ST_W-1:0]  status;
    } stage_t;

    function automatic axis_t make_axis(logic [POS_W-1:0] p, logic [CFG_W-1:0] q,
                                        logic [CFG_W-1:0] r, logic [CFG_W-1:0] border);
        axis_t            a;
        logic [CFG_W-1:0] rest;
        rest  = {1'b0, p} - border;
        a.rem = '0;
        a.quo = '0;
        if ({1'b0, p} < border) begin
            a.dvd  = p;
            a.div  = q + 13'd1;
            a.base = '0;
        end else begin
            a.dvd  = rest[POS_W-1:0];
            a.div  = q;
            a.base = r[POS_W-1:0];
        end
        return a;
    endfunction

endpackage

/* rtl/tmam_cfg.sv */
// Configuration registers and the per-axis tile split (quotient, remainder, border).
// Depends on tmam_pkg; the split is a restoring divider run after each write.
module tmam_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tmam_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [tmam_pkg::CFG_W-1:0]   cfg_data,
    output tmam_pkg::cfg_view_t          view
);
    import tmam_pkg::*;

    typedef enum logic [2:0] {
        CS_IDLE = 3'b001,
        CS_DIV  = 3'b010,
        CS_MUL  = 3'b100
    } cstate_t;

    cstate_t          state_reg, state_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [CFG_W-1:0] w_reg, w_next, h_reg, h_next, n_reg, n_next;
    logic [CFG_W-1:0] qw_reg, qw_next, rw_reg, rw_next, bw_reg, bw_next;
    logic [CFG_W-1:0] qh_reg, qh_next, rh_reg, rh_next, bh_reg, bh_next;
    logic [CFG_W-1:0] dw_reg, dw_next, dh_reg, dh_next;
    logic [CFG_W:0]   trial_w, trial_h, diff_w, diff_h;
    logic [2*CFG_W:0] prod_w, prod_h;

    assign cfg_ready = 1'b1;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        n_next     = n_reg;
        qw_next    = qw_reg;
        rw_next    = rw_reg;
        bw_next    = bw_reg;
        qh_next    = qh_reg;
        rh_next    = rh_reg;
        bh_next    = bh_reg;
        dw_next    = dw_reg;
        dh_next    = dh_reg;
        trial_w    = {rw_reg, dw_reg[CFG_W-1]};
        trial_h    = {rh_reg, dh_reg[CFG_W-1]};
        diff_w     = trial_w - {1'b0, n_reg};
        diff_h     = trial_h - {1'b0, n_reg};
        prod_w     = {1'b0, rw_reg} * {qw_reg + 13'd1};
        prod_h     = {1'b0, rh_reg} * {qh_reg + 13'd1};
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_WIDTH:  w_next = cfg_data;
                REG_HEIGHT: h_next = cfg_data;
                REG_TILE_N: n_next = cfg_data;
                default:    ;
            endcase
            state_next = CS_DIV;
            cnt_next   = '0;
            rw_next    = '0;
            rh_next    = '0;
            qw_next    = '0;
            qh_next    = '0;
            dw_next    = w_next;
            dh_next    = h_next;
        end else begin
            unique case (state_reg)
                CS_IDLE: ;
                CS_DIV: begin
                    if (trial_w >= {1'b0, n_reg}) begin
                        rw_next = diff_w[CFG_W-1:0];
                        qw_next = {qw_reg[CFG_W-2:0], 1'b1};
                    end else begin
                        rw_next = trial_w[CFG_W-1:0];
                        qw_next = {qw_reg[CFG_W-2:0], 1'b0};
                    end
                    if (trial_h >= {1'b0, n_reg}) begin
                        rh_next = diff_h[CFG_W-1:0];
                        qh_next = {qh_reg[CFG_W-2:0], 1'b1};
                    end else begin
                        rh_next = trial_h[CFG_W-1:0];
                        qh_next = {qh_reg[CFG_W-2:0], 1'b0};
                    end
                    dw_next  = {dw_reg[CFG_W-2:0], 1'b0};
                    dh_next  = {dh_reg[CFG_W-2:0], 1'b0};
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'(CFG_W - 1)) begin
                        state_next = CS_MUL;
                    end
                end
                CS_MUL: begin
                    bw_next    = prod_w[CFG_W-1:0];
                    bh_next    = prod_h[CFG_W-1:0];
                    state_next = CS_IDLE;
                end
                default: state_next = CS_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            cnt_reg   <= '0;
            w_reg     <= 13'd1;
            h_reg     <= 13'd1;
            n_reg     <= 13'd1;
            qw_reg    <= 13'd1;
            rw_reg    <= '0;
            bw_reg    <= '0;
            qh_reg    <= 13'd1;
            rh_reg    <= '0;
            bh_reg    <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            w_reg     <= w_next;
            h_reg     <= h_next;
            n_reg     <= n_next;
            qw_reg    <= qw_next;
            rw_reg    <= rw_next;
            bw_reg    <= bw_next;
            qh_reg    <= qh_next;
            rh_reg    <= rh_next;
            bh_reg    <= bh_next;
        end
    end

    always_ff @(posedge aclk) begin
        dw_reg <= dw_next;
        dh_reg <= dh_next;
    end

    assign view.width    = w_reg;
    assign view.height   = h_reg;
    assign view.tile_n   = n_reg;
    assign view.quot_w   = qw_reg;
    assign view.rem_w    = rw_reg;
    assign view.border_w = bw_reg;
    assign view.quot_h   = qh_reg;
    assign view.rem_h    = rh_reg;
    assign view.border_h = bh_reg;
    assign view.busy     = (state_reg != CS_IDLE);

endmodule

/* rtl/tmam_div_cell.sv */
// One cell of the division chain: one quotient bit for the row and column axes.
// Depends on tmam_pkg; a cell passes its stage_t on when the next cell can take it.
module tmam_div_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  tmam_pkg::stage_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output tmam_pkg::stage_t out_data
);
    import tmam_pkg::*;

    logic   valid_reg;
    stage_t data_reg, data_next;

    function automatic axis_t div_step(axis_t a);
        axis_t          r;
        logic [CFG_W:0] trial;
        logic [CFG_W:0] diff;
        r     = a;
        trial = {a.rem, a.dvd[POS_W-1]};
        diff  = trial - {1'b0, a.div};
        if (trial >= {1'b0, a.div}) begin
            r.rem = diff[CFG_W-1:0];
            r.quo = {a.quo[POS_W-2:0], 1'b1};
        end else begin
            r.rem = trial[CFG_W-1:0];
            r.quo = {a.quo[POS_W-2:0], 1'b0};
        end
        r.dvd = {a.dvd[POS_W-2:0], 1'b0};
        return r;
    endfunction

    always_comb begin
        data_next        = in_data;
        data_next.row_ax = div_step(in_data.row_ax);
        data_next.col_ax = div_step(in_data.col_ax);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

/* rtl/tile_mosaic_address_map_unit.sv */
// Top level of the tile mosaic address map: entry stage, division chain, products.
// Depends on tmam_pkg, tmam_cfg, tmam_div_cell and the assertion macro header.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | s_out_row, s_out_col
//   m_      | out       | m_valid / m_ready  | src row/col/index, tile row/col, status
//   cfg_    | in        | cfg_valid / ready  | cfg_index, cfg_data
//
// One transfer per cycle is sustained while m_ready is high and no split runs.
// Stages: entry, twelve division cells (one quotient bit each), two multiply stages.
// Reset loads the split of the reset configuration directly. After every configuration
// write the divider in tmam_cfg splits width and height by the tile factor; s_ready
// is low meanwhile.
// Each stage holds its item while the next one is full, so a stall fills the bubbles.
`include "tile_mosaic_address_map_unit_assert.svh"

module tile_mosaic_address_map_unit #(
    parameter int MAX_DIM = tmam_pkg::MAX_DIM_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [tmam_pkg::POS_W-1:0]   s_out_row,
    input  logic [tmam_pkg::POS_W-1:0]   s_out_col,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tmam_pkg::POS_W-1:0]   m_src_row,
    output logic [tmam_pkg::POS_W-1:0]   m_src_col,
    output logic [tmam_pkg::IDX_W-1:0]   m_src_index,
    output logic [tmam_pkg::POS_W-1:0]   m_tile_row,
    output logic [tmam_pkg::POS_W-1:0]   m_tile_col,
    output logic [tmam_pkg::ST_W-1:0]    m_status,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tmam_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [tmam_pkg::CFG_W-1:0]   cfg_data
);
    import tmam_pkg::*;

    cfg_view_t cfg;

    tmam_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .view      (cfg)
    );

    logic            node_valid [POS_W+1];
    logic            node_ready [POS_W+1];
    stage_t          node_data  [POS_W+1];

    logic            pre_valid_reg;
    stage_t          pre_reg, pre_next;
    logic            pre_ready;
    logic            bad_n;
    logic [16:0]     max_dim;

    assign max_dim = 17'(MAX_DIM);
    assign bad_n   = (cfg.tile_n == '0) || (cfg.tile_n > cfg.width) ||
                     (cfg.tile_n > cfg.height) ||
                     ({4'b0, cfg.width} > max_dim) || ({4'b0, cfg.height} > max_dim);

    always_comb begin
        pre_next.row_ax = make_axis(s_out_row, cfg.quot_h, cfg.rem_h, cfg.border_h);
        pre_next.col_ax = make_axis(s_out_col, cfg.quot_w, cfg.rem_w, cfg.border_w);
        if (bad_n) begin
            pre_next.status = ST_BAD_N;
        end else if (({1'b0, s_out_row} >= cfg.height) || ({1'b0, s_out_col} >= cfg.width)) begin
            pre_next.status = ST_OUTSIDE;
        end else begin
            pre_next.status = ST_OK;
        end
    end

    assign pre_ready = !pre_valid_reg || node_ready[0];
    assign s_ready   = pre_ready && !cfg.busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_valid_reg <= 1'b0;
        end else if (pre_ready) begin
            pre_valid_reg <= s_valid && s_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pre_reg <= pre_next;
        end
    end

    assign node_valid[0] = pre_valid_reg;
    assign node_data[0]  = pre_reg;

    for (genvar k = 0; k < POS_W; k++) begin : g_cell
        tmam_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (node_valid[k]),
            .in_ready  (node_ready[k]),
            .in_data   (node_data[k]),
            .out_valid (node_valid[k+1]),
            .out_ready (node_ready[k+1]),
            .out_data  (node_data[k+1])
        );
    end

    logic             mul_valid_reg, mul_ready, out_ready;
    logic [POS_W-1:0] srow_reg, scol_reg, trow_reg, tcol_reg;
    logic [ST_W-1:0]  mst_reg;
    logic [24:0]      prod_r, prod_c, prod_i;
    logic [24:0]      index_sum;
    stage_t           last;

    assign last      = node_data[POS_W];
    assign prod_r    = {13'b0, last.row_ax.rem[POS_W-1:0]} * {12'b0, cfg.tile_n};
    assign prod_c    = {13'b0, last.col_ax.rem[POS_W-1:0]} * {12'b0, cfg.tile_n};
    assign mul_ready = !mul_valid_reg || out_ready;
    assign node_ready[POS_W] = mul_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (mul_ready) begin
            mul_valid_reg <= node_valid[POS_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_ready && node_valid[POS_W]) begin
            srow_reg <= prod_r[POS_W-1:0];
            scol_reg <= prod_c[POS_W-1:0];
            trow_reg <= last.row_ax.base + last.row_ax.quo;
            tcol_reg <= last.col_ax.base + last.col_ax.quo;
            mst_reg  <= last.status;
        end
    end

    logic             m_valid_reg;
    logic [POS_W-1:0] m_src_row_reg, m_src_col_reg, m_tile_row_reg, m_tile_col_reg;
    logic [IDX_W-1:0] m_src_index_reg;
    logic [ST_W-1:0]  m_status_reg;
    logic             ok;

    assign prod_i    = {13'b0, srow_reg} * {12'b0, cfg.width};
    assign index_sum = prod_i + {13'b0, scol_reg};
    assign ok        = (mst_reg == ST_OK);
    assign out_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && mul_valid_reg) begin
            m_src_row_reg   <= ok ? srow_reg : '0;
            m_src_col_reg   <= ok ? scol_reg : '0;
            m_src_index_reg <= ok ? index_sum[IDX_W-1:0] : '0;
            m_tile_row_reg  <= ok ? trow_reg : '0;
            m_tile_col_reg  <= ok ? tcol_reg : '0;
            m_status_reg    <= mst_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_src_row   = m_src_row_reg;
    assign m_src_col   = m_src_col_reg;
    assign m_src_index = m_src_index_reg;
    assign m_tile_row  = m_tile_row_reg;
    assign m_tile_col  = m_tile_col_reg;
    assign m_status    = m_status_reg;

    `TMAM_ASSERT_ALWAYS(a_busy_blocks_input, aclk, aresetn, !(cfg.busy && s_ready))
    `TMAM_ASSERT_NEXT(a_write_starts_split, aclk, aresetn, cfg_valid && cfg_ready, !s_ready)
    `TMAM_ASSERT_ALWAYS(a_error_fields_zero, aclk, aresetn,
        !(m_valid && (m_status != ST_OK)) || ((m_src_index == '0) && (m_tile_row == '0)))
    `TMAM_ASSERT_ALWAYS(a_status_code, aclk, aresetn, !m_valid || (m_status != 2'd3))

endmodule

/* tb/tile_mosaic_address_map_unit_tb.sv */
// Testbench for tile_mosaic_address_map_unit: a directed table and random positions
// checked per field against the table or a mapping model. Depends on tmam_pkg.
module tile_mosaic_address_map_unit_tb;
    import tmam_pkg::*;

    localparam logic [CIDX_W-1:0] REG_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 30;

    typedef struct {
        logic [POS_W-1:0] src_row;
        logic [POS_W-1:0] src_col;
        logic [IDX_W-1:0] src_index;
        logic [POS_W-1:0] tile_row;
        logic [POS_W-1:0] tile_col;
        logic [ST_W-1:0]  status;
    } map_result_t;

    typedef struct {
        int unsigned      w;
        int unsigned      h;
        int unsigned      n;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        bit               typed;
        map_result_t      res;
    } dir_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [POS_W-1:0]    s_out_row = '0;
    logic [POS_W-1:0]    s_out_col = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [POS_W-1:0]    m_src_row;
    logic [POS_W-1:0]    m_src_col;
    logic [IDX_W-1:0]    m_src_index;
    logic [POS_W-1:0]    m_tile_row;
    logic [POS_W-1:0]    m_tile_col;
    logic [ST_W-1:0]     m_status;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;

    logic [CFG_W-1:0]    img_w = 13'd1;
    logic [CFG_W-1:0]    img_h = 13'd1;
    logic [CFG_W-1:0]    tile_n = 13'd1;

    map_result_t         pending_maps[$];
    dir_row_t            dir_tab[$];
    int                  errors = 0;
    int                  results_seen = 0;
    int                  items_sent = 0;
    int                  idle_cycles = 0;
    bit                  quiet = 1'b0;
    bit                  long_hold_req = 1'b0;

    tile_mosaic_address_map_unit dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Split one axis position into tile index and offset within the tile.
    function automatic void split_axis(input int unsigned p, input int unsigned size,
                                       input int unsigned n, output int unsigned tile,
                                       output int unsigned offs);
        int unsigned q;
        int unsigned r;
        int unsigned border;
        q = size / n;
        r = size % n;
        border = r * (q + 1);
        if (p < border) begin
            tile = p / (q + 1);
            offs = p % (q + 1);
        end else begin
            tile = r + (p - border) / q;
            offs = (p - border) % q;
        end
    endfunction

    function automatic map_result_t map_position(input logic [POS_W-1:0] row,
                                                 input logic [POS_W-1:0] col);
        map_result_t r;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned tr;
        int unsigned tc;
        int unsigned lr;
        int unsigned lc;
        w = img_w;
        h = img_h;
        n = tile_n;
        r = '{default: '0};
        if (n < 1 || n > w || n > h || w > MAX_DIM_DEF || h > MAX_DIM_DEF) begin
            r.status = ST_BAD_N;
        end else if (row >= h || col >= w) begin
            r.status = ST_OUTSIDE;
        end else begin
            split_axis(row, h, n, tr, lr);
            split_axis(col, w, n, tc, lc);
            r.status    = ST_OK;
            r.src_row   = POS_W'(lr * n);
            r.src_col   = POS_W'(lc * n);
            r.src_index = IDX_W'(lr * n * w + lc * n);
            r.tile_row  = POS_W'(tr);
            r.tile_col  = POS_W'(tc);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch on result %0d: %s is %0d, expected %0d",
                 results_seen, field, got, want);
        errors++;
    endtask

    task automatic wait_idle();
        while (pending_maps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input int unsigned data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(data);
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_WIDTH:  img_w  = CFG_W'(data);
            REG_HEIGHT: img_h  = CFG_W'(data);
            REG_TILE_N: tile_n = CFG_W'(data);
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int unsigned w, input int unsigned h, input int unsigned n);
        if (s_valid) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        wait_idle();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_TILE_N, n);
    endtask

    task automatic send_pos(input logic [POS_W-1:0] row, input logic [POS_W-1:0] col,
                            input bit typed, input map_result_t want);
        int gap;
        gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_out_row <= row;
        s_out_col <= col;
        do @(posedge aclk); while (!s_ready);
        pending_maps.push_back(typed ? want : map_position(row, col));
        items_sent++;
    endtask

    task automatic random_phase(input int count);
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned sel;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        sel = $urandom_range(0, 9);
        w = (sel < 5) ? $urandom_range(1, 64) : $urandom_range(1, 4096);
        h = (sel < 5) ? $urandom_range(1, 64) : $urandom_range(1, 4096);
        n = $urandom_range(1, (w < h) ? w : h);
        case ($urandom_range(0, 9))
            0: n = 0;
            1: n = $urandom_range(1, 8191);
            2: w = $urandom_range(4097, 8191);
            3: n = (w < h) ? w : h;
            default: ;
        endcase
        set_config(w, h, n);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                row = POS_W'($urandom);
                col = POS_W'($urandom);
            end else begin
                row = POS_W'($urandom_range(0, (h > 0 && h <= 4096) ? h - 1 : 4095));
                col = POS_W'($urandom_range(0, (w > 0 && w <= 4096) ? w - 1 : 4095));
            end
            send_pos(row, col, 1'b0, '{default: '0});
        end
    endtask

    // Result side: random ready bursts, plus one long hold on request.
    always @(negedge aclk) begin
        static int hold = 0;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (long_hold_req) begin
            hold = LONG_HOLD;
            long_hold_req = 1'b0;
            m_ready <= 1'b0;
        end else if (hold > 0) begin
            hold--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        map_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_maps.size() == 0) begin
                $display("unexpected result transfer %0d", results_seen);
                errors++;
            end else begin
                want = pending_maps.pop_front();
                if (m_status !== want.status) report_mismatch("status", m_status, want.status);
                if (m_src_row !== want.src_row)
                    report_mismatch("src_row", m_src_row, want.src_row);
                if (m_src_col !== want.src_col)
                    report_mismatch("src_col", m_src_col, want.src_col);
                if (m_src_index !== want.src_index)
                    report_mismatch("src_index", m_src_index, want.src_index);
                if (m_tile_row !== want.tile_row)
                    report_mismatch("tile_row", m_tile_row, want.tile_row);
                if (m_tile_col !== want.tile_col)
                    report_mismatch("tile_col", m_tile_col, want.tile_col);
            end
        end
        if (!aresetn || (m_valid && m_ready) || (s_valid && s_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", pending_maps.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        dir_row_t d;
        map_result_t zero;
        zero = '{default: '0};
        // Reset configuration is a 1 by 1 image with one tile.
        dir_tab.push_back('{1, 1, 1, 12'd0, 12'd0, 1'b1, '{0, 0, 0, 0, 0, ST_OK}});
        dir_tab.push_back('{1, 1, 1, 12'd0, 12'd1, 1'b1, '{0, 0, 0, 0, 0, ST_OUTSIDE}});
        dir_tab.push_back('{1, 1, 1, 12'd4095, 12'd4095, 1'b1, '{0, 0, 0, 0, 0, ST_OUTSIDE}});
        dir_tab.push_back('{4096, 4096, 1, 12'd4095, 12'd4095, 1'b1,
                            '{4095, 4095, 24'hFFFFFF, 0, 0, ST_OK}});
        dir_tab.push_back('{4096, 4096, 1, 12'd0, 12'd0, 1'b1, '{0, 0, 0, 0, 0, ST_OK}});
        dir_tab.push_back('{10, 10, 0, 12'd0, 12'd0, 1'b1, '{0, 0, 0, 0, 0, ST_BAD_N}});
        dir_tab.push_back('{10, 20, 11, 12'd0, 12'd0, 1'b1, '{0, 0, 0, 0, 0, ST_BAD_N}});
        dir_tab.push_back('{8191, 5, 1, 12'd0, 12'd0, 1'b1, '{0, 0, 0, 0, 0, ST_BAD_N}});
        dir_tab.push_back('{5, 5, 1, 12'd9, 12'd9, 1'b1, '{0, 0, 0, 0, 0, ST_OUTSIDE}});
        dir_tab.push_back('{10, 7, 3, 12'd0, 12'd0, 1'b0, zero});
        dir_tab.push_back('{10, 7, 3, 12'd2, 12'd3, 1'b0, zero});
        dir_tab.push_back('{10, 7, 3, 12'd6, 12'd9, 1'b0, zero});
        dir_tab.push_back('{10, 7, 3, 12'd3, 12'd4, 1'b0, zero});
        dir_tab.push_back('{10, 7, 3, 12'd7, 12'd0, 1'b1, '{0, 0, 0, 0, 0, ST_OUTSIDE}});
        dir_tab.push_back('{10, 7, 3, 12'd0, 12'd10, 1'b1, '{0, 0, 0, 0, 0, ST_OUTSIDE}});
        dir_tab.push_back('{4096, 4096, 4096, 12'd4095, 12'd4095, 1'b1,
                            '{0, 0, 0, 4095, 4095, ST_OK}});
        dir_tab.push_back('{4096, 4096, 4096, 12'd0, 12'd0, 1'b1, '{0, 0, 0, 0, 0, ST_OK}});
        dir_tab.push_back('{4096, 4096, 4097, 12'd1, 12'd1, 1'b1,
                            '{0, 0, 0, 0, 0, ST_BAD_N}});
        dir_tab.push_back('{100, 37, 7, 12'd36, 12'd99, 1'b0, zero});
        dir_tab.push_back('{100, 37, 7, 12'd5, 12'd15, 1'b0, zero});
        dir_tab.push_back('{100, 37, 7, 12'd2730, 12'd1365, 1'b1,
                            '{0, 0, 0, 0, 0, ST_OUTSIDE}});

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            d = dir_tab[i];
            if (d.w != img_w || d.h != img_h || d.n != tile_n) begin
                set_config(d.w, d.h, d.n);
                // An unmapped register index must leave the configuration alone.
                if (d.n == 3) write_reg(REG_NONE, 13'h1FFF);
            end
            send_pos(d.row, d.col, d.typed, d.res);
        end

        for (int p = 0; p < 9; p++) begin
            if (p == 2) begin
                set_config(64, 64, 5);
                long_hold_req = 1'b1;
                for (int i = 0; i < 100; i++)
                    send_pos(POS_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 63)),
                             1'b0, '{default: '0});
            end else begin
                random_phase(100);
            end
            if (p == 5) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                while (pending_maps.size() != 0) @(posedge aclk);
            end
        end
        quiet = 1'b1;
        random_phase(130);

        @(negedge aclk);
        s_valid <= 1'b0;
        wait_idle();
        $display("%0d positions sent, %0d results checked, across random image sizes",
                 items_sent, results_seen);
        $display("and tile factors including invalid and out-of-image cases");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
